// ===== src/rfp_pkg.sv =====
package rfp_pkg;

    localparam int TOTAL_W              = 12;
    localparam int BYTE_W               = 8;
    localparam int PKT_LEDS_DEF         = 20;
    localparam int PACKET_BYTES_DEF     = 64;
    localparam int HEADER_BYTE_DEF      = 136;
    localparam int QUEUE_DEPTH_DEF      = 4;

    // One LED as the back end needs it: colour plus packet framing marks.
    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic              start;
        logic              close;
        logic              frame_end;
        logic [BYTE_W-1:0] pkt_idx;
        logic [BYTE_W-1:0] pkt_count;
    } led_cmd_t;

    typedef struct packed {
        logic              busy;
        logic [BYTE_W-1:0] count;
    } cnt_status_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_HDR,
        PH_CNT,
        PH_IDX,
        PH_RED,
        PH_GRN,
        PH_BLU,
        PH_PAD,
        PH_SUM
    } phase_t;

endpackage

// ===== src/rfp_ifs.sv =====
interface rfp_led_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_in_packet;
    logic       last_in_frame;

    modport source (output valid, data_byte, last_in_packet, last_in_frame, input ready);
    modport sink   (input valid, data_byte, last_in_packet, last_in_frame, output ready);
endinterface

interface rfp_cfg_if;
    logic        valid;
    logic        ready;
    logic [11:0] total_leds;

    modport source (output valid, total_leds, input ready);
    modport sink   (input valid, total_leds, output ready);
endinterface

// ===== src/rfp_count_div.sv =====
module rfp_count_div
    import rfp_pkg::*;
#(
    parameter int DIVISOR = 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [TOTAL_W-1:0] total,
    output cnt_status_t        status
);

    localparam int DVD_W   = TOTAL_W + 1;
    localparam int SHIFT   = DVD_W + $clog2(DIVISOR);
    localparam int MUL_W   = DVD_W + 2;
    localparam int PROD_W  = SHIFT + DVD_W;
    localparam int MUL_INT = ((1 << SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam logic [MUL_W-1:0] MUL_C = MUL_W'(MUL_INT);
    localparam logic [DVD_W-1:0] ROUND = DVD_W'(DIVISOR - 1);

    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [BYTE_W-1:0] count_reg, count_next;
    logic              busy_reg, busy_next;
    logic [PROD_W-1:0] product;

    // ceil(total / DIVISOR): latch total + DIVISOR - 1, then a registered reciprocal
    // multiply in the cycle after, exact for any dividend below 2**DVD_W
    always_comb
    begin
        product    = PROD_W'(dvd_reg) * PROD_W'(MUL_C);
        dvd_next   = dvd_reg;
        count_next = count_reg;
        busy_next  = 1'b0;
        if (start)
        begin
            dvd_next  = DVD_W'(total) + ROUND;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            count_next = product[SHIFT +: BYTE_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvd_reg   <= '0;
            count_reg <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            dvd_reg   <= dvd_next;
            count_reg <= count_next;
            busy_reg  <= busy_next;
        end
    end

    assign status.busy  = busy_reg;
    assign status.count = count_reg;

endmodule

// ===== src/rfp_front.sv =====
module rfp_front
    import rfp_pkg::*;
#(
    parameter int PKT_LEDS     = PKT_LEDS_DEF,
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    rfp_led_if.sink            led,
    input  logic               cfg_wr,
    input  logic [TOTAL_W-1:0] cfg_total,
    input  cnt_status_t        cnt,
    input  logic               q_full,
    output logic               push,
    output led_cmd_t           cmd
);

    localparam int FIT   = (PACKET_BYTES - 4) / 3;
    localparam int EFF   = (PKT_LEDS < FIT) ? PKT_LEDS : ((FIT < 1) ? 1 : FIT);
    localparam int LIP_W = $clog2(EFF + 1);

    logic [TOTAL_W-1:0] total_reg;
    logic [LIP_W-1:0]   lip_reg, lip_next;
    logic [BYTE_W-1:0]  pkt_reg, pkt_next;
    logic [TOTAL_W-1:0] lif_reg, lif_next;

    logic               accept;
    logic [TOTAL_W-1:0] lif_inc;
    logic [LIP_W-1:0]   lip_inc;
    logic               frame_end;
    logic               close;

    assign led.ready = !cnt.busy && !q_full;
    assign accept    = led.valid && led.ready;
    // zero total: beats are taken and dropped
    assign push      = accept && (total_reg != '0);

    always_comb
    begin
        lif_inc   = lif_reg + 1'b1;
        lip_inc   = lip_reg + 1'b1;
        frame_end = (lif_inc >= total_reg);
        close     = frame_end || (lip_inc == LIP_W'(EFF));

        cmd.red       = led.red;
        cmd.green     = led.green;
        cmd.blue      = led.blue;
        cmd.start     = (lip_reg == '0);
        cmd.close     = close;
        cmd.frame_end = frame_end;
        cmd.pkt_idx   = pkt_reg + 1'b1;
        cmd.pkt_count = cnt.count;

        lip_next = lip_reg;
        pkt_next = pkt_reg;
        lif_next = lif_reg;
        if (push)
        begin
            if (close)
            begin
                lip_next = '0;
                if (frame_end)
                begin
                    pkt_next = '0;
                    lif_next = '0;
                end
                else
                begin
                    pkt_next = pkt_reg + 1'b1;
                    lif_next = lif_inc;
                end
            end
            else
            begin
                lip_next = lip_inc;
                lif_next = lif_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            lip_reg   <= '0;
            pkt_reg   <= '0;
            lif_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            total_reg <= cfg_total;
            lip_reg   <= '0;
            pkt_reg   <= '0;
            lif_reg   <= '0;
        end
        else
        begin
            lip_reg <= lip_next;
            pkt_reg <= pkt_next;
            lif_reg <= lif_next;
        end
    end

endmodule

// ===== src/rfp_queue.sv =====
module rfp_queue
    import rfp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  led_cmd_t din,
    input  logic     pop,
    output led_cmd_t dout,
    output logic     full,
    output logic     empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    led_cmd_t         entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    assign full  = (fill_reg == CNT_W'(DEPTH));
    assign empty = (fill_reg == '0);
    assign dout  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== src/rfp_back.sv =====
module rfp_back
    import rfp_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF,
    parameter int HEADER_BYTE  = HEADER_BYTE_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_wr,
    input  led_cmd_t  cmd,
    input  logic      empty,
    output logic      pop,
    rfp_byte_if.source stream
);

    localparam int POS_W = $clog2(PACKET_BYTES);
    localparam logic [POS_W-1:0]  SUM_POS = POS_W'(PACKET_BYTES - 1);
    localparam logic [BYTE_W-1:0] HDR     = BYTE_W'(HEADER_BYTE);

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic              valid_reg;
    logic [BYTE_W-1:0] data_reg;
    logic              lastp_reg;
    logic              lastf_reg;

    phase_t            cur;
    logic [POS_W-1:0]  pos_inc;
    logic [BYTE_W-1:0] byte_val;
    logic              lastp;
    logic              lastf;
    logic              done;
    logic              advance;

    assign advance = !empty && (!valid_reg || stream.ready);
    assign pop     = advance && done;

    always_comb
    begin
        cur      = (phase_reg == PH_IDLE) ? (cmd.start ? PH_HDR : PH_RED) : phase_reg;
        pos_inc  = pos_reg + 1'b1;
        byte_val = '0;
        lastp    = 1'b0;
        lastf    = 1'b0;
        done     = 1'b0;
        phase_next = phase_reg;
        case (cur)
            PH_HDR:
            begin
                byte_val   = HDR;
                phase_next = PH_CNT;
            end
            PH_CNT:
            begin
                byte_val   = cmd.pkt_count;
                phase_next = PH_IDX;
            end
            PH_IDX:
            begin
                byte_val   = cmd.pkt_idx;
                phase_next = PH_RED;
            end
            PH_RED:
            begin
                byte_val   = cmd.red;
                phase_next = PH_GRN;
            end
            PH_GRN:
            begin
                byte_val   = cmd.green;
                phase_next = PH_BLU;
            end
            PH_BLU:
            begin
                byte_val = cmd.blue;
                if (!cmd.close)
                begin
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    phase_next = (pos_inc < SUM_POS) ? PH_PAD : PH_SUM;
                end
            end
            PH_PAD:
            begin
                byte_val   = '0;
                phase_next = (pos_inc < SUM_POS) ? PH_PAD : PH_SUM;
            end
            PH_SUM:
            begin
                byte_val   = sum_reg;
                lastp      = 1'b1;
                lastf      = cmd.frame_end;
                done       = 1'b1;
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        sum_next = (cur == PH_HDR) ? HDR : sum_reg + byte_val;
        pos_next = (cur == PH_SUM) ? '0 : pos_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            sum_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            valid_reg <= 1'b1;
        end
        else if (stream.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg  <= byte_val;
            lastp_reg <= lastp;
            lastf_reg <= lastf;
        end
    end

    assign stream.valid          = valid_reg;
    assign stream.data_byte      = data_reg;
    assign stream.last_in_packet = lastp_reg;
    assign stream.last_in_frame  = lastf_reg;

endmodule

// ===== src/rgb_frame_packetizer.sv =====
// channel   dir   beat payload
// led       in    red, green, blue (one LED)
// stream    out   data_byte, last_in_packet, last_in_frame (one packet byte)
// cfg       in    total_leds (write, always ready)
//
// Output runs at one byte per cycle while stream is ready and the queue is not empty:
// an LED costs 3 bytes, each packet adds 3 header bytes, zero padding and the checksum
// (64 bytes per full packet). The front takes one LED per cycle into a 4-entry queue
// while no count is forming and it is not full, so input bursts outrun output. After a
// total_leds write, led is held off while a reciprocal multiply forms the packet count.
// rst_n is asynchronous; a stalled stream holds its byte and backs up through the queue.
module rgb_frame_packetizer
    import rfp_pkg::*;
#(
    parameter int PKT_LEDS     = PKT_LEDS_DEF,
    parameter int PACKET_BYTES = PACKET_BYTES_DEF,
    parameter int HEADER_BYTE  = HEADER_BYTE_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    rfp_led_if.sink    led,
    rfp_byte_if.source stream,
    rfp_cfg_if.sink    cfg
);

    localparam int FIT = (PACKET_BYTES - 4) / 3;
    localparam int EFF = (PKT_LEDS < FIT) ? PKT_LEDS : ((FIT < 1) ? 1 : FIT);

    logic        cfg_wr;
    cnt_status_t cnt;
    led_cmd_t    q_din;
    led_cmd_t    q_dout;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;

    rfp_count_div #(
        .DIVISOR (EFF)
    ) u_count_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cfg_wr),
        .total  (cfg.total_leds),
        .status (cnt)
    );

    rfp_front #(
        .PKT_LEDS     (PKT_LEDS),
        .PACKET_BYTES (PACKET_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .led       (led),
        .cfg_wr    (cfg_wr),
        .cfg_total (cfg.total_leds),
        .cnt       (cnt),
        .q_full    (q_full),
        .push      (q_push),
        .cmd       (q_din)
    );

    rfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    rfp_back #(
        .PACKET_BYTES (PACKET_BYTES),
        .HEADER_BYTE  (HEADER_BYTE)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_wr (cfg_wr),
        .cmd    (q_dout),
        .empty  (q_empty),
        .pop    (q_pop),
        .stream (stream)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    a_div_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> cnt.busy)
        else $error("packet count not started after write");

    a_frame_end_on_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_dout.frame_end) |-> q_dout.close)
        else $error("frame end popped without closing its packet");
`endif

endmodule
